// ===== rtl/tcp_session_tracker_top_macros.svh =====
// Assertion macros used by the back part of the tracker (tst_back).
`ifndef TCP_SESSION_TRACKER_TOP_MACROS_SVH
`define TCP_SESSION_TRACKER_TOP_MACROS_SVH
`ifndef SYNTH
// Checked property, disabled while reset is high.
`define TST_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define TST_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TST_ASSERT(name, clk, rst, prop, msg)
`define TST_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== rtl/tst_pkg.sv =====
package tst_pkg;

  // Table geometry.
  localparam int MAX_SESSIONS = 64;
  localparam int IDX_W        = $clog2(MAX_SESSIONS);
  localparam int CNT_W        = $clog2(MAX_SESSIONS + 1);

  // Item queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] IDLE_RESET = 16'd300;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_SWEEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_UNKNOWN,
    ST_CONNECTING,
    ST_CONNECTED,
    ST_DISCONNECTING,
    ST_DISCONNECTED
  } conn_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_COMMIT
  } bk_state_t;

  // One session entry as held in the table memory.
  typedef struct packed {
    logic [31:0]  server_addr;
    logic [31:0]  client_addr;
    logic [15:0]  server_port_no;
    logic [15:0]  client_port_no;
    conn_status_t session_status;
    logic         roles_unknown;
    logic         last_dir_s2c;
    logic [30:0]  connect_time;
    logic [30:0]  disconnect_time;
    logic [30:0]  last_seen_time;
    logic [29:0]  frames_low;
    logic [31:0]  frames_high;
    logic [29:0]  bytes_low;
    logic [31:0]  bytes_high;
  } entry_t;

  // A classified item handed from the front part to the back part.
  typedef struct packed {
    logic        kind;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_tcp_port;
    logic [15:0] dst_tcp_port;
    logic        syn_flag;
    logic        ack_flag;
    logic        fin_flag;
    logic [15:0] frame_bytes;
    logic [30:0] now_seconds;
    logic        create_new;
    logic        srv_is_dst;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic         found;
    logic         created;
    logic         no_room;
    logic [5:0]   entry_index;
    logic         server_to_client;
    conn_status_t conn_status;
    logic         roles_guessed;
    logic [61:0]  frame_count;
    logic [61:0]  byte_count;
    logic [6:0]   removed_count;
  } res_t;

endpackage

// ===== rtl/tst_in_if.sv =====
interface tst_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_tcp_port;
  logic [15:0] dst_tcp_port;
  logic        syn_flag;
  logic        ack_flag;
  logic        fin_flag;
  logic [15:0] frame_bytes;
  logic [30:0] now_seconds;
  logic        create_new;

  modport source (
    output valid, kind, src_ip, dst_ip, src_tcp_port, dst_tcp_port, syn_flag, ack_flag,
           fin_flag, frame_bytes, now_seconds, create_new,
    input  ready
  );
  modport sink (
    input  valid, kind, src_ip, dst_ip, src_tcp_port, dst_tcp_port, syn_flag, ack_flag,
           fin_flag, frame_bytes, now_seconds, create_new,
    output ready
  );
endinterface

// ===== rtl/tst_out_if.sv =====
interface tst_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        created;
  logic        no_room;
  logic [5:0]  entry_index;
  logic        server_to_client;
  logic [2:0]  conn_status;
  logic        roles_guessed;
  logic [61:0] frame_count;
  logic [61:0] byte_count;
  logic [6:0]  removed_count;

  modport source (
    output valid, found, created, no_room, entry_index, server_to_client,
           conn_status, roles_guessed, frame_count, byte_count, removed_count,
    input  ready
  );
  modport sink (
    input  valid, found, created, no_room, entry_index, server_to_client,
           conn_status, roles_guessed, frame_count, byte_count, removed_count,
    output ready
  );
endinterface

// ===== rtl/tcp_session_tracker_top.sv =====
// TCP session tracker. Each beat on items is either a packet (kind 0), which is
// matched on its 4-tuple in either direction against a table of MAX_SESSIONS slots,
// or a sweep (kind 1), which frees closing and idle sessions; every beat yields
// exactly one beat on results. An item is taken from the queue, then the table is
// walked one slot per cycle through the registered read port of the memory, then
// the write-back and the result are committed. A packet that matches stops the walk
// at the matching slot. Items queue two deep ahead of the walk, and a finished
// result waits in an output register, which holds off the next commit until it is
// taken. There is no clearing pass after reset. idle_timeout resets to 300 and is
// written through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module tcp_session_tracker_top import tst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tst_in_if.sink      items,
  tst_out_if.source   results,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] idle_timeout;
  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_ready;

  // Idle timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_RESET;
    end else if (cfg_we) begin
      idle_timeout <= cfg_wdata;
    end
  end

  tst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  tst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .idle_timeout (idle_timeout),
    .results      (results)
  );

endmodule

// ===== rtl/tst_ram.sv =====
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/tst_front.sv =====
module tst_front import tst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tst_in_if.sink     items,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  cmd_t              in_cmd;

  // Classify the beat: with SYN or src port >= dst port the receiver is the server.
  always_comb begin
    in_cmd.kind         = items.kind;
    in_cmd.src_ip       = items.src_ip;
    in_cmd.dst_ip       = items.dst_ip;
    in_cmd.src_tcp_port = items.src_tcp_port;
    in_cmd.dst_tcp_port = items.dst_tcp_port;
    in_cmd.syn_flag     = items.syn_flag;
    in_cmd.ack_flag     = items.ack_flag;
    in_cmd.fin_flag     = items.fin_flag;
    in_cmd.frame_bytes  = items.frame_bytes;
    in_cmd.now_seconds  = items.now_seconds;
    in_cmd.create_new   = items.create_new;
    in_cmd.srv_is_dst   = items.syn_flag | (items.src_tcp_port >= items.dst_tcp_port);
  end

  assign items.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push        = items.valid & items.ready;
  assign cmd_valid   = (count != '0);
  assign pop         = cmd_valid & cmd_ready;
  assign cmd         = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tst_back.sv =====
`include "tcp_session_tracker_top_macros.svh"

module tst_back import tst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [15:0] idle_timeout,
  tst_out_if.source   results
);

  bk_state_t         state;
  bk_state_t         state_next;
  cmd_t              cur;
  logic [IDX_W:0]    iss;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic              valid_bits [MAX_SESSIONS];
  logic              hit;
  logic              dir_s2c;
  logic [IDX_W-1:0]  slot;
  entry_t            match_ent;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  removed;
  logic              out_valid;
  res_t              out_res;

  entry_t            rd_ent;
  entry_t            base;
  entry_t            upd;
  res_t              res;
  logic              issue;
  logic              ent_valid;
  logic              m_s2c;
  logic              m_c2s;
  logic              last_ent;
  logic [30:0]       diff;
  logic              drop;
  logic              scan_done;
  logic              out_free;
  logic              commit_fire;
  logic              ram_we;
  logic [IDX_W-1:0]  slot_sel;
  logic [30:0]       fsum;
  logic [30:0]       bsum;

  // Session table memory, one entry per slot.
  tst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_SESSIONS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot_sel),
    .wr_data (upd),
    .rd_addr (iss[IDX_W-1:0]),
    .rd_data (rd_ent)
  );

  // Compare the entry returned by the memory against the current item.
  always_comb begin
    issue     = (state == BK_SCAN) && (iss < (IDX_W + 1)'(MAX_SESSIONS));
    ent_valid = valid_bits[cmp_idx];
    m_s2c = (rd_ent.server_addr == cur.src_ip) && (rd_ent.client_addr == cur.dst_ip) &&
            (rd_ent.server_port_no == cur.src_tcp_port) &&
            (rd_ent.client_port_no == cur.dst_tcp_port);
    m_c2s = (rd_ent.server_addr == cur.dst_ip) && (rd_ent.client_addr == cur.src_ip) &&
            (rd_ent.server_port_no == cur.dst_tcp_port) &&
            (rd_ent.client_port_no == cur.src_tcp_port);
    last_ent = (cmp_idx == IDX_W'(MAX_SESSIONS - 1));
    diff = (cur.now_seconds >= rd_ent.last_seen_time) ?
           cur.now_seconds - rd_ent.last_seen_time :
           rd_ent.last_seen_time - cur.now_seconds;
    drop = (rd_ent.session_status >= ST_DISCONNECTING) ||
           ((rd_ent.last_seen_time != '0) && (diff > {15'd0, idle_timeout}));
    scan_done = (state == BK_SCAN) && cmp_vld &&
                (last_ent || ((cur.kind == KIND_PACKET) && ent_valid && (m_s2c || m_c2s)));
  end

  // Build the updated entry for the matched or newly created session.
  always_comb begin
    if (hit) begin
      base = match_ent;
      base.last_dir_s2c = dir_s2c;
      if ((base.session_status >= ST_DISCONNECTING) && cur.ack_flag) begin
        base.session_status  = ST_CONNECTING;
        base.disconnect_time = '0;
      end
    end else begin
      base.server_addr     = cur.srv_is_dst ? cur.dst_ip : cur.src_ip;
      base.client_addr     = cur.srv_is_dst ? cur.src_ip : cur.dst_ip;
      base.server_port_no  = cur.srv_is_dst ? cur.dst_tcp_port : cur.src_tcp_port;
      base.client_port_no  = cur.srv_is_dst ? cur.src_tcp_port : cur.dst_tcp_port;
      base.last_dir_s2c    = ~cur.srv_is_dst;
      base.roles_unknown   = ~cur.syn_flag;
      base.session_status  = cur.syn_flag ? ST_CONNECTING : ST_UNKNOWN;
      base.connect_time    = cur.now_seconds;
      base.disconnect_time = '0;
      base.last_seen_time  = '0;
      base.frames_low      = '0;
      base.frames_high     = '0;
      base.bytes_low       = '0;
      base.bytes_high      = '0;
    end
    upd = base;
    if ((upd.session_status == ST_CONNECTING) && (upd.frames_low != '0) && cur.ack_flag) begin
      upd.session_status = ST_CONNECTED;
    end
    if (cur.fin_flag) begin
      upd.disconnect_time = cur.now_seconds;
      upd.session_status  = ST_DISCONNECTING;
    end else if ((upd.session_status == ST_DISCONNECTING) && cur.ack_flag) begin
      upd.session_status = ST_DISCONNECTED;
    end
    // Low halves carry into the high halves at 2^30.
    fsum = {1'b0, base.frames_low} + 31'd1;
    bsum = {1'b0, base.bytes_low} + {15'd0, cur.frame_bytes};
    upd.frames_low  = fsum[29:0];
    upd.frames_high = base.frames_high + {31'd0, fsum[30]};
    upd.bytes_low   = bsum[29:0];
    upd.bytes_high  = base.bytes_high + {31'd0, bsum[30]};
    upd.last_seen_time = cur.now_seconds;
  end

  // Commit control and the result of the item.
  always_comb begin
    out_free    = !out_valid || results.ready;
    commit_fire = (state == BK_COMMIT) && out_free;
    slot_sel    = hit ? slot : free_idx;
    ram_we      = commit_fire && (cur.kind == KIND_PACKET) &&
                  (hit || (cur.create_new && free_found));
    res = '0;
    if (cur.kind == KIND_SWEEP) begin
      res.removed_count = 7'(removed);
    end else if (hit || (cur.create_new && free_found)) begin
      res.found            = hit;
      res.created          = ~hit;
      res.entry_index      = 6'(slot_sel);
      res.server_to_client = upd.last_dir_s2c;
      res.conn_status      = upd.session_status;
      res.roles_guessed    = upd.roles_unknown;
      res.frame_count      = {upd.frames_high, upd.frames_low};
      res.byte_count       = {upd.bytes_high, upd.bytes_low};
    end else if (cur.create_new) begin
      res.no_room = 1'b1;
    end
  end

  // Sequencer: take an item, walk the table, then commit.
  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    case (state)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_next = BK_COMMIT;
        end
      end
      BK_COMMIT: begin
        if (commit_fire) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      removed    <= '0;
      iss        <= '0;
    end else if (state == BK_IDLE) begin
      cmp_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      removed    <= '0;
      iss        <= '0;
      if (cmd_valid) begin
        cur <= cmd;
      end
    end else if (state == BK_SCAN) begin
      cmp_vld <= issue;
      cmp_idx <= iss[IDX_W-1:0];
      if (issue) begin
        iss <= iss + 1'b1;
      end
      if (cmp_vld) begin
        if (cur.kind == KIND_SWEEP) begin
          if (ent_valid && drop) begin
            removed <= removed + 1'b1;
          end
        end else if (ent_valid && (m_s2c || m_c2s)) begin
          hit       <= 1'b1;
          dir_s2c   <= m_s2c;
          slot      <= cmp_idx;
          match_ent <= rd_ent;
        end else if (!ent_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SESSIONS; i++) begin
        valid_bits[i] <= 1'b0;
      end
    end else if ((state == BK_SCAN) && cmp_vld && (cur.kind == KIND_SWEEP) && ent_valid &&
                 drop) begin
      valid_bits[cmp_idx] <= 1'b0;
    end else if (ram_we) begin
      valid_bits[slot_sel] <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      out_res <= res;
    end
  end

  assign results.valid            = out_valid;
  assign results.found            = out_res.found;
  assign results.created          = out_res.created;
  assign results.no_room          = out_res.no_room;
  assign results.entry_index      = out_res.entry_index;
  assign results.server_to_client = out_res.server_to_client;
  assign results.conn_status      = out_res.conn_status;
  assign results.roles_guessed    = out_res.roles_guessed;
  assign results.frame_count      = out_res.frame_count;
  assign results.byte_count       = out_res.byte_count;
  assign results.removed_count    = out_res.removed_count;

  // Checks on the sequencer, the scan datapath and the output register.
  `TST_ASSERT(a_store_in_commit, clk, rst, ram_we |-> (state == BK_COMMIT && cur.kind == KIND_PACKET), "table write outside commit of a packet")
  `TST_ASSERT(a_removed_bound, clk, rst, removed <= CNT_W'(MAX_SESSIONS), "removed count exceeds table size")
  `TST_ASSERT(a_hit_valid, clk, rst, (state == BK_COMMIT && hit) |-> valid_bits[slot], "matched slot is not valid")
  `TST_ASSERT(a_commit_loads, clk, rst, commit_fire |=> out_valid, "commit did not load the output register")

endmodule
